/* design/dshb_pkg.sv */
// Shared types, constants and helper functions of the dashed rounded border shader.
`default_nettype none
package dshb_pkg;

  localparam int FRAC_BITS = 8;
  localparam int IFB       = FRAC_BITS + 1;
  localparam int MAX_DIM   = 1024;
  localparam int DIM_W     = 11;
  localparam int LEN_CFG_W = 18;
  localparam int LW        = 28;
  localparam int AW        = 22;
  localparam int CW        = 38;
  localparam int QB        = LW - IFB;
  localparam int PRE_SH    = 8;
  localparam int IDX_W     = 3;
  localparam int DATA_W    = 32;

  typedef logic signed [LW-1:0] len_t;
  typedef logic signed [AW-1:0] ang_t;
  typedef logic signed [CW-1:0] vec_t;

  localparam len_t ONE_L    = len_t'(1 << IFB);
  localparam len_t HALF_PIX = len_t'(1 << FRAC_BITS);
  localparam len_t EDGE_OFS = len_t'(3 << (FRAC_BITS - 1));

  localparam ang_t A_HALF_PI = ang_t'(102944);
  localparam ang_t A_PI      = ang_t'(205887);
  localparam ang_t A_TWO_PI  = ang_t'(411775);
  localparam logic signed [21:0] INV_GAIN = 22'sd636751;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH      = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT     = 3'd1;
  localparam logic [IDX_W-1:0] REG_CORNER_RADIUS    = 3'd2;
  localparam logic [IDX_W-1:0] REG_STROKE_THICKNESS = 3'd3;
  localparam logic [IDX_W-1:0] REG_DASH_LENGTH      = 3'd4;
  localparam logic [IDX_W-1:0] REG_GAP_LENGTH       = 3'd5;
  localparam logic [IDX_W-1:0] REG_STROKE_COLOR     = 3'd6;

  typedef struct packed {
    logic [DIM_W-1:0]     image_width;
    logic [DIM_W-1:0]     image_height;
    logic [LEN_CFG_W-1:0] corner_radius;
    logic [LEN_CFG_W-1:0] stroke_thickness;
    logic [LEN_CFG_W-1:0] dash_length;
    logic [LEN_CFG_W-1:0] gap_length;
    logic [31:0]          stroke_color;
  } cfg_t;

  typedef struct packed {
    len_t xl;
    len_t yt;
    len_t xr;
    len_t yb;
    len_t c2t;
    len_t span;
    len_t rr;
    len_t lx;
    len_t rx;
    len_t ty;
    len_t by;
    logic signed [45:0] qa_prod;
    len_t hs;
    len_t vs;
    len_t qa;
    len_t off_tl;
    len_t off_br;
    len_t off_bl;
    len_t off_r;
    len_t off_b;
  } geo_t;

  typedef struct packed {
    logic corner;
    vec_t vx;
    vec_t vy;
    ang_t z;
    ang_t a0;
    len_t rr;
    len_t offs;
    len_t s_pos;
    len_t s_dist;
  } cd_t;

  typedef struct packed {
    len_t pos;
    len_t pdist;
  } pd_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] coverage;
  } px_t;

  function automatic len_t lmin(input len_t a, input len_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic len_t lmax(input len_t a, input len_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic len_t labs(input len_t a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic ang_t atan_val(input int k);
    ang_t v;
    case (k)
      0:       v = ang_t'(51472);
      1:       v = ang_t'(30386);
      2:       v = ang_t'(16055);
      3:       v = ang_t'(8150);
      4:       v = ang_t'(4091);
      5:       v = ang_t'(2047);
      6:       v = ang_t'(1024);
      7:       v = ang_t'(512);
      8:       v = ang_t'(256);
      9:       v = ang_t'(128);
      10:      v = ang_t'(64);
      11:      v = ang_t'(32);
      12:      v = ang_t'(16);
      13:      v = ang_t'(8);
      14:      v = ang_t'(4);
      15:      v = ang_t'(2);
      16:      v = ang_t'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* design/dshb_ifs.sv */
// Stream interfaces for pixel coordinates in and shaded colour beats out.
`default_nettype none
interface dshb_pix_if;
  logic       valid;
  logic       ready;
  logic [9:0] pixel_x;
  logic [9:0] pixel_y;
  modport source(output valid, output pixel_x, output pixel_y, input ready);
  modport sink(input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface dshb_rgba_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] coverage_out;
  modport source(output valid, output red_out, output green_out, output blue_out,
                 output coverage_out, input ready);
  modport sink(input valid, input red_out, input green_out, input blue_out,
               input coverage_out, output ready);
endinterface
`default_nettype wire

/* design/dshb_geom.sv */
// Geometry stages: derived path setup, region split, straight-edge distance and CORDIC seed.
`default_nettype none
module dshb_geom (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [9:0]    pixel_x,
  input  wire logic [9:0]    pixel_y,
  input  wire dshb_pkg::cfg_t cfg,
  output logic               out_valid,
  output dshb_pkg::cd_t      out
);
  import dshb_pkg::*;

  localparam int PD = 6;

  typedef struct packed {
    logic corner;
    len_t dx;
    len_t dy;
    len_t offs;
    ang_t a0;
    len_t c0;
    len_t c1;
    len_t c2;
    len_t c3;
    len_t cx;
    len_t cy;
  } sa_t;

  logic [DIM_W-1:0] wd, ht;
  len_t t_len;
  geo_t g1, g2, g3, g4, g5, g6;
  geo_t g1_next, g2_next, g3_next, g4_next, g5_next, g6_next;

  logic p_v [1:PD];
  len_t p_qx [1:PD];
  len_t p_qy [1:PD];

  sa_t  a_next, a;
  logic a_v;
  cd_t  b_next;
  len_t ox, oy;

  always_comb begin
    wd = cfg.image_width;
    if (cfg.image_width == '0) wd = DIM_W'(1);
    else if (cfg.image_width > DIM_W'(MAX_DIM)) wd = DIM_W'(MAX_DIM);
    ht = cfg.image_height;
    if (cfg.image_height == '0) ht = DIM_W'(1);
    else if (cfg.image_height > DIM_W'(MAX_DIM)) ht = DIM_W'(MAX_DIM);
    t_len = len_t'(cfg.stroke_thickness);
  end

  always_comb begin
    g1_next     = '0;
    g1_next.xl  = t_len;
    g1_next.yt  = t_len;
    g1_next.xr  = (len_t'(wd) <<< IFB) - t_len;
    g1_next.yb  = (len_t'(ht) <<< IFB) - t_len;
    g1_next.c2t = (len_t'(cfg.corner_radius) <<< 1) - t_len;

    g2_next      = g1;
    g2_next.span = lmin(g1.xr - g1.xl, g1.yb - g1.yt);

    g3_next    = g2;
    g3_next.rr = lmax(ONE_L, lmin(g2.c2t, (g2.span > 0) ? (g2.span >>> 1) : len_t'(0)));

    g4_next         = g3;
    g4_next.lx      = g3.xl + g3.rr;
    g4_next.rx      = g3.xr - g3.rr;
    g4_next.ty      = g3.yt + g3.rr;
    g4_next.by      = g3.yb - g3.rr;
    g4_next.qa_prod = g3.rr * A_HALF_PI;

    g5_next    = g4;
    g5_next.hs = lmax(len_t'(0), g4.rx - g4.lx);
    g5_next.vs = lmax(len_t'(0), g4.by - g4.ty);
    g5_next.qa = len_t'((g4.qa_prod + 46'sd32768) >>> 16);

    g6_next        = g5;
    g6_next.off_tl = (g5.hs <<< 1) + (g5.vs <<< 1) + g5.qa + (g5.qa <<< 1);
    g6_next.off_br = g5.hs + g5.qa + g5.vs;
    g6_next.off_bl = (g5.hs <<< 1) + g5.vs + (g5.qa <<< 1);
    g6_next.off_r  = g5.hs + g5.qa;
    g6_next.off_b  = g5.hs + (g5.qa <<< 1) + g5.vs;
  end

  always_ff @(posedge clk) begin
    g1 <= g1_next;
    g2 <= g2_next;
    g3 <= g3_next;
    g4 <= g4_next;
    g5 <= g5_next;
    g6 <= g6_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= PD; i++) p_v[i] <= 1'b0;
      a_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_v[1] <= in_valid;
      for (int i = 2; i <= PD; i++) p_v[i] <= p_v[i-1];
      a_v       <= p_v[PD];
      out_valid <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_qx[1] <= (len_t'(pixel_x) <<< IFB) + HALF_PIX;
      p_qy[1] <= (len_t'(pixel_y) <<< IFB) + HALF_PIX;
      for (int i = 2; i <= PD; i++) begin
        p_qx[i] <= p_qx[i-1];
        p_qy[i] <= p_qy[i-1];
      end
      a   <= a_next;
      out <= b_next;
    end
  end

  always_comb begin
    a_next        = '0;
    ox            = g6.lx;
    oy            = g6.ty;
    a_next.corner = 1'b1;
    priority if (p_qx[PD] < g6.lx && p_qy[PD] < g6.ty) begin
      a_next.offs = g6.off_tl;
      a_next.a0   = A_PI;
    end else if (p_qx[PD] > g6.rx && p_qy[PD] < g6.ty) begin
      ox          = g6.rx;
      a_next.offs = g6.hs;
      a_next.a0   = -A_HALF_PI;
    end else if (p_qx[PD] > g6.rx && p_qy[PD] > g6.by) begin
      ox          = g6.rx;
      oy          = g6.by;
      a_next.offs = g6.off_br;
      a_next.a0   = '0;
    end else if (p_qx[PD] < g6.lx && p_qy[PD] > g6.by) begin
      oy          = g6.by;
      a_next.offs = g6.off_bl;
      a_next.a0   = A_HALF_PI;
    end else begin
      a_next.corner = 1'b0;
    end
    a_next.dx = p_qx[PD] - ox;
    a_next.dy = p_qy[PD] - oy;
    a_next.c0 = labs(p_qy[PD] - g6.yt);
    a_next.c1 = labs(p_qx[PD] - g6.xr);
    a_next.c2 = labs(p_qy[PD] - g6.yb);
    a_next.c3 = labs(p_qx[PD] - g6.xl);
    a_next.cx = lmax(lmin(p_qx[PD], g6.rx), g6.lx);
    a_next.cy = lmax(lmin(p_qy[PD], g6.by), g6.ty);
  end

  always_comb begin
    logic [1:0] sel;
    len_t best;
    b_next        = '0;
    b_next.corner = a.corner;
    b_next.a0     = a.a0;
    b_next.rr     = g6.rr;
    b_next.offs   = a.offs;
    if (a.dx < 0) begin
      b_next.vx = vec_t'(-a.dx) <<< PRE_SH;
      b_next.vy = vec_t'(-a.dy) <<< PRE_SH;
      b_next.z  = (a.dy >= 0) ? A_PI : -A_PI;
    end else begin
      b_next.vx = vec_t'(a.dx) <<< PRE_SH;
      b_next.vy = vec_t'(a.dy) <<< PRE_SH;
      b_next.z  = '0;
    end
    sel  = 2'd0;
    best = a.c0;
    if (a.c1 < best) begin
      sel  = 2'd1;
      best = a.c1;
    end
    if (a.c2 < best) begin
      sel  = 2'd2;
      best = a.c2;
    end
    if (a.c3 < best) begin
      sel  = 2'd3;
      best = a.c3;
    end
    b_next.s_dist = best;
    unique case (sel)
      2'd0: b_next.s_pos = a.cx - g6.lx;
      2'd1: b_next.s_pos = g6.off_r + a.cy - g6.ty;
      2'd2: b_next.s_pos = g6.off_b + g6.rx - a.cx;
      2'd3: b_next.s_pos = g6.off_bl + g6.qa + g6.by - a.cy;
    endcase
  end

endmodule
`default_nettype wire

/* design/dshb_cordic.sv */
// CORDIC vectoring pipeline, gain removal, and corner arc or edge position out.
`default_nettype none
module dshb_cordic #(
  parameter int STEPS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire dshb_pkg::cd_t in,
  output logic               out_valid,
  output dshb_pkg::pd_t      out
);
  import dshb_pkg::*;

  cd_t  st [1:STEPS];
  logic sv [1:STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    cd_t  cur, nxt;
    logic cv;
    if (k == 0) begin : g_first
      assign cur = in;
      assign cv  = in_valid;
    end else begin : g_rest
      assign cur = st[k];
      assign cv  = sv[k];
    end
    always_comb begin
      nxt = cur;
      if (cur.vy > 0) begin
        nxt.vx = cur.vx + (cur.vy >>> k);
        nxt.vy = cur.vy - (cur.vx >>> k);
        nxt.z  = cur.z + atan_val(k);
      end else begin
        nxt.vx = cur.vx - (cur.vy >>> k);
        nxt.vy = cur.vy + (cur.vx >>> k);
        nxt.z  = cur.z - atan_val(k);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (en) begin
        sv[k+1] <= cv;
      end
    end
    always_ff @(posedge clk) begin
      if (en) st[k+1] <= nxt;
    end
  end

  logic               m1_v, m2_v, m3_v;
  cd_t                m1;
  logic signed [59:0] m1_prod;
  cd_t                m2;
  len_t               m2_dist;
  ang_t               m2_diff;
  cd_t                m3;
  len_t               m3_dist;
  logic signed [49:0] m3_ap;
  len_t               mag;
  ang_t               ang;

  always_comb begin
    mag = len_t'((m1_prod + 60'sd134217728) >>> 28);
    ang = (m1.z < m1.a0) ? (m1.z + A_TWO_PI) : m1.z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v      <= 1'b0;
      m2_v      <= 1'b0;
      m3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      m1_v      <= sv[STEPS];
      m2_v      <= m1_v;
      m3_v      <= m2_v;
      out_valid <= m3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1      <= st[STEPS];
      m1_prod <= st[STEPS].vx * INV_GAIN;
      m2      <= m1;
      m2_dist <= labs(mag - m1.rr);
      m2_diff <= ang - m1.a0;
      m3      <= m2;
      m3_dist <= m2_dist;
      m3_ap   <= m2_diff * m2.rr;
      if (m3.corner) begin
        out.pos   <= m3.offs + len_t'((m3_ap + 50'sd32768) >>> 16);
        out.pdist <= m3_dist;
      end else begin
        out.pos   <= m3.s_pos;
        out.pdist <= m3.s_dist;
      end
    end
  end

endmodule
`default_nettype wire

/* design/dshb_dash.sv */
// Dash phase remainder pipeline, edge and dash ramps, and coverage rounding.
`default_nettype none
module dshb_dash (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire dshb_pkg::pd_t  in,
  input  wire dshb_pkg::cfg_t cfg,
  output logic                out_valid,
  output dshb_pkg::px_t       out
);
  import dshb_pkg::*;

  typedef struct packed {
    logic          neg;
    logic [LW-1:0] r;
    len_t          pdist;
  } dv_t;

  dv_t  dq  [0:QB];
  logic dqv [0:QB];

  logic [20:0] per;
  len_t        dash_i;
  len_t        n;

  function automatic logic [IFB:0] ramp(input len_t x);
    logic [IFB:0] v;
    if (x < 0) v = '0;
    else if (x > ONE_L) v = ONE_L[IFB:0];
    else v = x[IFB:0];
    return v;
  endfunction

  always_comb begin
    per    = 21'({3'b0, cfg.dash_length} + {3'b0, cfg.gap_length}) << 1;
    if (per < 21'(ONE_L)) per = 21'(ONE_L);
    dash_i = len_t'(cfg.dash_length) <<< 1;
    n      = in.pos + len_t'(cfg.dash_length);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dqv[0] <= 1'b0;
    end else if (en) begin
      dqv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq[0].neg   <= n < 0;
      dq[0].r     <= (n < 0) ? LW'(-n) : LW'(n);
      dq[0].pdist <= in.pdist;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_rem
    localparam int BI = QB - 1 - k;
    dv_t nxt;
    always_comb begin
      nxt = dq[k];
      if ((dq[k].r >> BI) >= LW'(per)) nxt.r = dq[k].r - (LW'(per) << BI);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dqv[k+1] <= 1'b0;
      end else if (en) begin
        dqv[k+1] <= dqv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) dq[k+1] <= nxt;
    end
  end

  len_t             ph;
  logic [IFB:0]     eg_next, da_next;
  logic             e1_v, e2_v;
  logic [IFB:0]     e1_eg, e1_da;
  logic [2*IFB+1:0] e2_m;
  logic [28:0]      prod;
  logic [10:0]      cov_w;
  logic [7:0]       cov;

  always_comb begin
    ph      = dq[QB].neg ? -len_t'(dq[QB].r) : len_t'(dq[QB].r);
    da_next = '0;
    if (ph <= dash_i) da_next = ramp(lmin(ph + HALF_PIX, dash_i - ph + HALF_PIX));
    eg_next = ramp(len_t'(cfg.stroke_thickness) + EDGE_OFS - dq[QB].pdist);
    prod    = 29'(cfg.stroke_color[31:24]) * 29'(e2_m) + 29'(1 << (2 * IFB - 1));
    cov_w   = prod[28:2*IFB];
    cov     = (cov_w > 11'd255) ? 8'd255 : cov_w[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v      <= 1'b0;
      e2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      e1_v      <= dqv[QB];
      e2_v      <= e1_v;
      out_valid <= e2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_eg        <= eg_next;
      e1_da        <= da_next;
      e2_m         <= e1_eg * e1_da;
      out.coverage <= cov;
      out.red      <= (cov != '0) ? cfg.stroke_color[7:0] : 8'd0;
      out.green    <= (cov != '0) ? cfg.stroke_color[15:8] : 8'd0;
      out.blue     <= (cov != '0) ? cfg.stroke_color[23:16] : 8'd0;
    end
  end

endmodule
`default_nettype wire

/* design/dashed_rounded_border_shader.sv */
// Top level of the dashed rounded-rectangle border shader.
//
//   channel  dir  beat contents
//   pix      in   pixel_x, pixel_y
//   rgba     out  red_out, green_out, blue_out, coverage_out
//   wr_*     in   wr_index, wr_data (register write, no read-back)
//
// One pixel per clock while output beats are taken; each pixel passes the geometry stages, the CORDIC
// vectoring stages and the dash stages with their one-bit-per-stage remainder pipeline.
// Synchronous active-high reset clears the valid bits and resets the registers (width and height to 1, the rest to 0).
// A stalled output beat holds the whole pipeline; nothing is lost or repeated.
`default_nettype none
module dashed_rounded_border_shader #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  dshb_pix_if.sink                         pix,
  dshb_rgba_if.source                      rgba,
  input  wire logic                        wr_en,
  input  wire logic [dshb_pkg::IDX_W-1:0]  wr_index,
  input  wire logic [dshb_pkg::DATA_W-1:0] wr_data
);
  import dshb_pkg::*;

  cfg_t cfg;
  logic en;
  logic g_v, c_v, d_v;
  cd_t  g_out;
  pd_t  c_out;
  px_t  d_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width      <= DIM_W'(1);
      cfg.image_height     <= DIM_W'(1);
      cfg.corner_radius    <= '0;
      cfg.stroke_thickness <= '0;
      cfg.dash_length      <= '0;
      cfg.gap_length       <= '0;
      cfg.stroke_color     <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_IMAGE_WIDTH:      cfg.image_width      <= wr_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT:     cfg.image_height     <= wr_data[DIM_W-1:0];
        REG_CORNER_RADIUS:    cfg.corner_radius    <= wr_data[LEN_CFG_W-1:0];
        REG_STROKE_THICKNESS: cfg.stroke_thickness <= wr_data[LEN_CFG_W-1:0];
        REG_DASH_LENGTH:      cfg.dash_length      <= wr_data[LEN_CFG_W-1:0];
        REG_GAP_LENGTH:       cfg.gap_length       <= wr_data[LEN_CFG_W-1:0];
        REG_STROKE_COLOR:     cfg.stroke_color     <= wr_data;
        default: begin
        end
      endcase
    end
  end

  assign en        = !d_v || rgba.ready;
  assign pix.ready = en;

  dshb_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pix.valid),
    .pixel_x   (pix.pixel_x),
    .pixel_y   (pix.pixel_y),
    .cfg       (cfg),
    .out_valid (g_v),
    .out       (g_out)
  );

  dshb_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (g_v),
    .in        (g_out),
    .out_valid (c_v),
    .out       (c_out)
  );

  dshb_dash u_dash (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_v),
    .in        (c_out),
    .cfg       (cfg),
    .out_valid (d_v),
    .out       (d_out)
  );

  assign rgba.valid        = d_v;
  assign rgba.red_out      = d_out.red;
  assign rgba.green_out    = d_out.green;
  assign rgba.blue_out     = d_out.blue;
  assign rgba.coverage_out = d_out.coverage;

endmodule
`default_nettype wire

/* tb/dashed_rounded_border_shader_test.sv */
// Testbench for the dashed rounded border shader: predicted pixels checked against output beats.
`timescale 1ns / 1ps
module dashed_rounded_border_shader_test;
  import dshb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [IDX_W-1:0] wr_index = '0;
  logic [DATA_W-1:0] wr_data = '0;

  dshb_pix_if pix ();
  dshb_rgba_if rgba ();

  dashed_rounded_border_shader u_top (
    .clk(clk), .rst(rst), .pix(pix), .rgba(rgba),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  longint m_width, m_height, m_radius, m_thick, m_dash, m_gap, m_color;
  px_t expected_px[$];
  int errors = 0;
  int beats_seen = 0;
  int pixels_sent = 0;
  bit idle_on = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  function automatic longint lmn(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint lmx(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint lab(longint a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic longint atan_step(int k);
    longint tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256, 128,
                        64, 32, 16, 8, 4, 2, 1};
    return (k < 17) ? tab[k] : 0;
  endfunction

  function automatic void corner_arc(longint qx, longint qy, longint ox, longint oy,
                                     longint rr, longint offs, longint a0,
                                     output longint pdist, output longint pos);
    longint dx, dy, vx, vy, z, sx, sy, mag, ang;
    dx = qx - ox;
    dy = qy - oy;
    if (dx < 0) begin
      vx = -dx * 256;
      vy = -dy * 256;
      z = (dy >= 0) ? 205887 : -205887;
    end else begin
      vx = dx * 256;
      vy = dy * 256;
      z = 0;
    end
    for (int k = 0; k < 16; k++) begin
      sx = vx >>> k;
      sy = vy >>> k;
      if (vy > 0) begin
        vx += sy; vy -= sx; z += atan_step(k);
      end else begin
        vx -= sy; vy += sx; z -= atan_step(k);
      end
    end
    mag = (vx * 636751 + (64'sd1 <<< 27)) >>> 28;
    pdist = lab(mag - rr);
    ang = z;
    if (ang < a0) ang += 411775;
    pos = offs + (((ang - a0) * rr + (64'sd1 <<< 15)) >>> 16);
  endfunction

  function automatic px_t shade_pixel(logic [9:0] x, logic [9:0] y);
    longint qx, qy, wd, ht, ht_, xl, yt, xr, yb, span, rr, lx, rx, ty, by, hs, vs, qa;
    longint pdist, pos, dash_i, per, ph, da, eg, c0, c1, c2, c3, alpha, prod, cov;
    px_t r;
    qx = (longint'(x) <<< 9) + 256;
    qy = (longint'(y) <<< 9) + 256;
    wd = lmx(1, lmn(m_width, 1024));
    ht = lmx(1, lmn(m_height, 1024));
    ht_ = m_thick;
    xl = ht_; yt = ht_;
    xr = (wd <<< 9) - ht_;
    yb = (ht <<< 9) - ht_;
    span = lmn(xr - xl, yb - yt);
    rr = lmx(512, lmn(m_radius * 2 - ht_, (span > 0) ? span / 2 : 0));
    lx = xl + rr; rx = xr - rr; ty = yt + rr; by = yb - rr;
    hs = lmx(0, rx - lx);
    vs = lmx(0, by - ty);
    qa = (rr * 102944 + 32768) >>> 16;
    if (qx < lx && qy < ty)
      corner_arc(qx, qy, lx, ty, rr, 2*hs + 2*vs + 3*qa, 205887, pdist, pos);
    else if (qx > rx && qy < ty)
      corner_arc(qx, qy, rx, ty, rr, hs, -102944, pdist, pos);
    else if (qx > rx && qy > by)
      corner_arc(qx, qy, rx, by, rr, hs + qa + vs, 0, pdist, pos);
    else if (qx < lx && qy > by)
      corner_arc(qx, qy, lx, by, rr, 2*hs + vs + 2*qa, 102944, pdist, pos);
    else begin
      c0 = lab(qy - yt); c1 = lab(qx - xr); c2 = lab(qy - yb); c3 = lab(qx - xl);
      if (c0 <= c1 && c0 <= c2 && c0 <= c3) begin
        pdist = c0; pos = lmx(lx, lmn(qx, rx)) - lx;
      end else if (c1 <= c2 && c1 <= c3) begin
        pdist = c1; pos = hs + qa + lmx(ty, lmn(qy, by)) - ty;
      end else if (c2 <= c3) begin
        pdist = c2; pos = hs + 2*qa + vs + rx - lmx(lx, lmn(qx, rx));
      end else begin
        pdist = c3; pos = 2*hs + vs + 3*qa + by - lmx(ty, lmn(qy, by));
      end
    end
    dash_i = m_dash * 2;
    per = lmx(512, (m_dash + m_gap) * 2);
    ph = (pos + m_dash) % per;
    if (ph <= dash_i) da = lmx(0, lmn(lmn(ph + 256, dash_i - ph + 256), 512));
    else da = 0;
    eg = lmx(0, lmn(ht_ + 384 - pdist, 512));
    alpha = (m_color >> 24) & 255;
    prod = alpha * eg * da;
    cov = (prod + (64'sd1 <<< 17)) >>> 18;
    if (cov > 255) cov = 255;
    r.coverage = cov[7:0];
    r.red = (cov != 0) ? m_color[7:0] : 8'd0;
    r.green = (cov != 0) ? m_color[15:8] : 8'd0;
    r.blue = (cov != 0) ? m_color[23:16] : 8'd0;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
    $display("mismatch beat %0d %s: got %0d expected %0d", beats_seen, field, got, want);
    errors++;
  endtask

  always @(negedge clk) begin
    rgba.ready <= idle_on ? ($urandom_range(99) >= 11) : 1'b1;
  end

  always @(posedge clk) begin
    px_t w;
    if (!rst && rgba.valid && rgba.ready) begin
      if (expected_px.size() == 0) begin
        report_mismatch("unexpected", rgba.coverage_out, 8'd0);
      end else begin
        w = expected_px.pop_front();
        if (rgba.red_out !== w.red) report_mismatch("red", rgba.red_out, w.red);
        if (rgba.green_out !== w.green) report_mismatch("green", rgba.green_out, w.green);
        if (rgba.blue_out !== w.blue) report_mismatch("blue", rgba.blue_out, w.blue);
        if (rgba.coverage_out !== w.coverage)
          report_mismatch("coverage", rgba.coverage_out, w.coverage);
      end
      beats_seen++;
    end
  end

  task automatic send_pixel(logic [9:0] x, logic [9:0] y);
    if (idle_on && $urandom_range(99) < 11) begin
      pix.valid = 1'b0;
      @(negedge clk);
    end
    pix.valid = 1'b1;
    pix.pixel_x = x;
    pix.pixel_y = y;
    do @(posedge clk); while (!pix.ready);
    expected_px.push_back(shade_pixel(x, y));
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    pix.valid = 1'b0;
    while (expected_px.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, longint value);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = value[DATA_W-1:0];
    @(negedge clk);
    wr_en = 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:      m_width = value & 'h7FF;
      REG_IMAGE_HEIGHT:     m_height = value & 'h7FF;
      REG_CORNER_RADIUS:    m_radius = value & 'h3FFFF;
      REG_STROKE_THICKNESS: m_thick = value & 'h3FFFF;
      REG_DASH_LENGTH:      m_dash = value & 'h3FFFF;
      REG_GAP_LENGTH:       m_gap = value & 'h3FFFF;
      REG_STROKE_COLOR:     m_color = value & 'hFFFFFFFF;
      default: ;
    endcase
  endtask

  task automatic load_shape(longint w, longint h, longint rad, longint th, longint d,
                            longint g, longint c);
    drain_pipe();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_CORNER_RADIUS, rad);
    write_reg(REG_STROKE_THICKNESS, th);
    write_reg(REG_DASH_LENGTH, d);
    write_reg(REG_GAP_LENGTH, g);
    write_reg(REG_STROKE_COLOR, c);
  endtask

  task automatic test_reset_defaults();
    send_pixel(0, 0);
    send_pixel(1023, 1023);
  endtask

  task automatic test_directed_shapes();
    load_shape(64, 48, 8 << 8, 2 << 8, 6 << 8, 3 << 8, 'hFF3366CC);
    send_pixel(0, 0); send_pixel(2, 2); send_pixel(32, 1); send_pixel(62, 1);
    send_pixel(62, 46); send_pixel(1, 46); send_pixel(1, 24); send_pixel(63, 20);
    send_pixel(32, 24); send_pixel(1023, 0); send_pixel(0, 1023);
    load_shape(0, 2047, 'h3FFFF, 'h3FFFF, 0, 0, 'hFFFFFFFF);
    send_pixel(0, 0); send_pixel(512, 700); send_pixel(1023, 1023);
    load_shape(2047, 0, 0, 0, 'h3FFFF, 'h3FFFF, 'h80102030);
    send_pixel(0, 0); send_pixel(1023, 0); send_pixel(500, 1);
    load_shape(8, 8, 0, 20 << 8, 1, 0, 'h01FFFFFF);
    send_pixel(0, 0); send_pixel(4, 4); send_pixel(7, 3);
  endtask

  task automatic test_random_shapes(int phases, int per_phase);
    longint w, h;
    logic [9:0] x, y;
    for (int p = 0; p < phases; p++) begin
      w = (p % 7 == 0) ? longint'($urandom_range(0, 2047)) : longint'($urandom_range(1, 160));
      h = (p % 5 == 0) ? longint'($urandom_range(0, 2047)) : longint'($urandom_range(1, 160));
      load_shape(w, h,
                 (p % 9 == 4) ? 'h3FFFF : longint'($urandom_range(0, 40 << 8)),
                 (p % 11 == 3) ? longint'($urandom_range(0, 'h3FFFF))
                               : longint'($urandom_range(0, 6 << 8)),
                 (p % 8 == 6) ? 'h3FFFF : longint'($urandom_range(0, 30 << 8)),
                 (p % 10 == 2) ? 0 : longint'($urandom_range(0, 30 << 8)),
                 longint'($urandom()));
      idle_on = (p % 4 != 1);
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(99) < 20) begin
          x = 10'($urandom());
          y = 10'($urandom());
        end else begin
          x = 10'($urandom_range(0, int'(lmn(w + 3, 1023))));
          y = 10'($urandom_range(0, int'(lmn(h + 3, 1023))));
        end
        send_pixel(x, y);
        if (i == per_phase / 2 && p % 6 == 0) drain_pipe();
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    pix.valid = 1'b0;
    pix.pixel_x = '0;
    pix.pixel_y = '0;
    rgba.ready = 1'b0;
    m_width = 1; m_height = 1; m_radius = 0; m_thick = 0;
    m_dash = 0; m_gap = 0; m_color = 0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    idle_on = 1'b1;
    test_reset_defaults();
    test_directed_shapes();
    test_random_shapes(23, 50);
    drain_pipe();
    $display("shaded %0d pixels over many shapes, spans, dash patterns and colors", pixels_sent);
    $display("checked %0d output beats with random stalls on both sides", beats_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
